@@ design/pcs_pkg.sv @@
// Shared types and constants for the priority counting semaphore.
// No dependencies; imported by the interfaces, datapath, controller and top level.
`timescale 1ns / 1ps

package pcs_pkg;

  localparam int PRIO_W     = 6;
  localparam int CNT_W      = 8;
  localparam int STATUS_W   = 3;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [CNT_W-1:0] FREE_MAX   = 8'hFF;
  localparam logic [CNT_W-1:0] FREE_RESET = 8'd1;

  localparam logic KIND_DOWN = 1'b0;

  // register index, taken from paddr above the byte offset
  typedef enum logic [0:0] {
    REG_INITIAL_COUNT = 1'b0
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_FULL      = 3'd2,
    ST_RAISED    = 3'd3,
    ST_WOKEN     = 3'd4,
    ST_SATURATED = 3'd5
  } status_t;

  // datapath commands issued by the controller
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_CAPTURE,
    OP_GRANT,
    OP_REFUSE,
    OP_RAISE,
    OP_SATURATE,
    OP_PUSH_START,
    OP_PUSH_RD,
    OP_PUSH_MOVE,
    OP_PLACE,
    OP_POP_RD_TOP,
    OP_POP_RD_LAST,
    OP_POP_LOAD,
    OP_DN_RDL,
    OP_DN_RDR,
    OP_DN_STEP,
    OP_EMIT
  } dp_op_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic is_up;
    logic free_zero;
    logic free_max;
    logic fill_zero;
    logic fill_full;
    logic idx_zero;
    logic push_less;
    logic l_in;
    logic sink;
    logic out_free;
  } dp_sts_t;

endpackage

@@ design/pcs_req_if.sv @@
// Request channel: valid/ready handshake with kind, task id and nice level.
// Depends on pcs_pkg.
`timescale 1ns / 1ps

interface pcs_req_if import pcs_pkg::*; #(
  parameter int TASK_ID_BITS = 8
) ();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [TASK_ID_BITS-1:0]  task_id;
  logic signed [PRIO_W-1:0] priority_req;

  modport source (output valid, kind, task_id, priority_req, input ready);
  modport sink   (input valid, kind, task_id, priority_req, output ready);
endinterface

@@ design/pcs_rsp_if.sv @@
// Result channel: valid/ready handshake with status, woken task and count.
// Depends on pcs_pkg.
`timescale 1ns / 1ps

interface pcs_rsp_if import pcs_pkg::*; #(
  parameter int TASK_ID_BITS = 8,
  parameter int WAIT_W       = 5
) ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [TASK_ID_BITS-1:0]  woken_task;
  logic signed [PRIO_W-1:0] woken_priority;
  logic [WAIT_W-1:0]        waiters;

  modport source (output valid, status, woken_task, woken_priority, waiters, input ready);
  modport sink   (input valid, status, woken_task, woken_priority, waiters, output ready);
endinterface

@@ design/pcs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module pcs_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/pcs_datapath.sv @@
// Datapath: counters, heap index and entry registers, heap RAM, result register.
// Depends on pcs_pkg and pcs_ram; driven by commands from pcs_ctrl.
`timescale 1ns / 1ps

module pcs_datapath import pcs_pkg::*; #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8,
  localparam int WAIT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CNT_W-1:0]         cfg_wdata,
  output logic [CNT_W-1:0]         cfg_value,
  input  logic                     in_kind,
  input  logic [TASK_ID_BITS-1:0]  in_task,
  input  logic signed [PRIO_W-1:0] in_prio,
  input  dp_op_t                   cmd,
  output dp_sts_t                  sts,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [STATUS_W-1:0]      out_status,
  output logic [TASK_ID_BITS-1:0]  out_task,
  output logic signed [PRIO_W-1:0] out_prio,
  output logic [WAIT_W-1:0]        out_waiters
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = IW + 2;
  localparam int EW = TASK_ID_BITS + PRIO_W;

  logic [CNT_W-1:0]  initial_count;
  logic [CNT_W-1:0]  free_units;
  logic [WAIT_W-1:0] fill;
  logic [IW-1:0]     idx;
  logic [EW-1:0]     cur;
  logic [EW-1:0]     lbuf;
  logic [EW-1:0]     top;
  logic              kind_r;
  status_t           res_status;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [IW-1:0] parent;
  logic [CW-1:0] lchild;
  logic [CW-1:0] rchild;
  logic [CW-1:0] fill_c;
  logic          l_in;
  logic          r_in;
  logic          take_l;
  logic          take_r;

  logic signed [PRIO_W-1:0] cur_prio;
  logic signed [PRIO_W-1:0] rd_prio;
  logic signed [PRIO_W-1:0] lb_prio;

  pcs_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_heap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cur_prio = cur[PRIO_W-1:0];
  assign rd_prio  = ram_rdata[PRIO_W-1:0];
  assign lb_prio  = lbuf[PRIO_W-1:0];

  assign parent = (idx - IW'(1)) >> 1;
  assign lchild = CW'({idx, 1'b1});
  assign rchild = CW'({idx, 1'b0}) + CW'(2);
  assign fill_c = CW'(fill);
  assign l_in   = lchild < fill_c;
  assign r_in   = rchild < fill_c;

  // strict less-than, left child wins ties
  assign take_l = l_in && (lb_prio < cur_prio);
  assign take_r = r_in && (rd_prio < (take_l ? lb_prio : cur_prio));

  assign cfg_value = initial_count;

  always_comb begin
    sts.is_up     = (kind_r != KIND_DOWN);
    sts.free_zero = (free_units == '0);
    sts.free_max  = (free_units == FREE_MAX);
    sts.fill_zero = (fill == '0);
    sts.fill_full = (fill == WAIT_W'(QUEUE_DEPTH));
    sts.idx_zero  = (idx == '0);
    sts.push_less = (cur_prio < rd_prio);
    sts.l_in      = l_in;
    sts.sink      = !take_l && !take_r;
    sts.out_free  = !out_valid || out_ready;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = cur;
    ram_raddr = '0;
    case (cmd)
      OP_PUSH_RD:     ram_raddr = parent;
      OP_PUSH_MOVE: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      OP_PLACE:       ram_we = 1'b1;
      OP_POP_RD_LAST: ram_raddr = fill[IW-1:0];
      OP_DN_RDL:      ram_raddr = lchild[IW-1:0];
      OP_DN_RDR:      ram_raddr = rchild[IW-1:0];
      OP_DN_STEP: begin
        ram_we    = 1'b1;
        ram_wdata = take_r ? ram_rdata : (take_l ? lbuf : cur);
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_count <= FREE_RESET;
      free_units    <= FREE_RESET;
      fill          <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        initial_count <= cfg_wdata;
        free_units    <= cfg_wdata;
        fill          <= '0;
      end
      case (cmd)
        OP_GRANT:      free_units <= free_units - CNT_W'(1);
        OP_RAISE:      free_units <= free_units + CNT_W'(1);
        OP_PUSH_START: fill <= fill + WAIT_W'(1);
        OP_POP_RD_TOP: fill <= fill - WAIT_W'(1);
        OP_EMIT:       out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd)
      OP_CAPTURE: begin
        cur    <= {in_task, in_prio};
        kind_r <= in_kind;
      end
      OP_GRANT:    res_status <= ST_GRANTED;
      OP_REFUSE:   res_status <= ST_FULL;
      OP_RAISE:    res_status <= ST_RAISED;
      OP_SATURATE: res_status <= ST_SATURATED;
      OP_PUSH_START: begin
        idx        <= fill[IW-1:0];
        res_status <= ST_QUEUED;
      end
      OP_PUSH_MOVE:   idx <= parent;
      OP_POP_RD_TOP:  res_status <= ST_WOKEN;
      OP_POP_RD_LAST: top <= ram_rdata;
      OP_POP_LOAD: begin
        cur <= ram_rdata;
        idx <= '0;
      end
      OP_DN_RDR: lbuf <= ram_rdata;
      OP_DN_STEP: begin
        if (take_r) begin
          idx <= rchild[IW-1:0];
        end else if (take_l) begin
          idx <= lchild[IW-1:0];
        end
      end
      OP_EMIT: begin
        out_status  <= res_status;
        out_waiters <= fill;
        if (res_status == ST_WOKEN) begin
          out_task <= top[EW-1:PRIO_W];
          out_prio <= top[PRIO_W-1:0];
        end else begin
          out_task <= '0;
          out_prio <= '0;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= WAIT_W'(QUEUE_DEPTH))
    else $error("heap fill beyond queue depth");

  a_wait_only_when_empty: assert property (@(posedge clk) disable iff (rst)
    (free_units == '0) || (fill == '0))
    else $error("tasks waiting while free units remain");

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd == OP_EMIT) |-> (!out_valid || out_ready))
    else $error("result overwrites one not yet taken");

  a_woken_leaves_room: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == ST_WOKEN)) |-> (out_waiters < WAIT_W'(QUEUE_DEPTH)))
    else $error("woken result with full queue");
`endif

endmodule

@@ design/pcs_ctrl.sv @@
// Controller: sequences grant, sift-up push and sift-down pop per request.
// Depends on pcs_pkg; drives pcs_datapath by command.
`timescale 1ns / 1ps

module pcs_ctrl import pcs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_op_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_PU_CHK,
    S_PU_CMP,
    S_PO_LAST,
    S_PO_LOAD,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = OP_IDLE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = OP_CAPTURE;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.is_up) begin
          if (!sts.free_zero) begin
            cmd        = OP_GRANT;
            state_next = S_EMIT;
          end else if (sts.fill_full) begin
            cmd        = OP_REFUSE;
            state_next = S_EMIT;
          end else begin
            cmd        = OP_PUSH_START;
            state_next = S_PU_CHK;
          end
        end else if (sts.fill_zero) begin
          cmd        = sts.free_max ? OP_SATURATE : OP_RAISE;
          state_next = S_EMIT;
        end else begin
          cmd        = OP_POP_RD_TOP;
          state_next = S_PO_LAST;
        end
      end
      S_PU_CHK: begin
        if (sts.idx_zero) begin
          cmd        = OP_PLACE;
          state_next = S_EMIT;
        end else begin
          cmd        = OP_PUSH_RD;
          state_next = S_PU_CMP;
        end
      end
      S_PU_CMP: begin
        if (sts.push_less) begin
          cmd        = OP_PUSH_MOVE;
          state_next = S_PU_CHK;
        end else begin
          cmd        = OP_PLACE;
          state_next = S_EMIT;
        end
      end
      S_PO_LAST: begin
        cmd        = OP_POP_RD_LAST;
        state_next = S_PO_LOAD;
      end
      S_PO_LOAD: begin
        cmd        = OP_POP_LOAD;
        state_next = sts.fill_zero ? S_EMIT : S_DN_L;
      end
      S_DN_L: begin
        if (sts.l_in) begin
          cmd        = OP_DN_RDL;
          state_next = S_DN_R;
        end else begin
          cmd        = OP_PLACE;
          state_next = S_EMIT;
        end
      end
      S_DN_R: begin
        cmd        = OP_DN_RDR;
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd        = OP_DN_STEP;
        state_next = sts.sink ? S_EMIT : S_DN_L;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd        = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in work");

  a_emit_then_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd == OP_EMIT) |=> in_ready)
    else $error("controller not idle after emitting a result");

  a_step_from_compare: assert property (@(posedge clk) disable iff (rst)
    (cmd == OP_DN_STEP) |-> ($past(cmd) == OP_DN_RDR))
    else $error("sift-down step without both children read");
`endif

endmodule

@@ design/priority_counting_semaphore.sv @@
// Top level of the priority counting semaphore: APB register, controller, datapath.
// Depends on pcs_pkg, pcs_req_if, pcs_rsp_if, pcs_ctrl and pcs_datapath.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  req     | in        | valid / ready        | kind, task_id, priority_req
//  rsp     | out       | valid / ready        | status, woken_task, woken_priority, waiters
//  apb     | in        | psel/penable/pready  | paddr, pwdata, prdata (initial_count)
//
// One request is in work at a time. Steps from accept to result valid:
//   grant / refuse / raise / saturate : decide, then emit
//   down that queues (sift-up)        : per level read and compare parent, then place
//   up that wakes a waiter (sift-down): pop top, load last entry, then per level read
//                                       and compare left and right child (skipped if emptied)
// The heap RAM has one read port with registered data, so each heap level costs
// one read (sift-up) or two reads (left and right child, sift-down). Reset: free
// units = 1, queue empty. A write to initial_count reloads the free count and
// empties the queue. A stalled result holds in the output register; the next
// request is still accepted and worked on, and its result waits for that slot.
`timescale 1ns / 1ps

module priority_counting_semaphore import pcs_pkg::*; #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int TASK_ID_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  pcs_req_if.sink               req,
  pcs_rsp_if.source             rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int WAIT_W = $clog2(QUEUE_DEPTH + 1);

  dp_op_t           cmd;
  dp_sts_t          sts;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_value;

  // register index sits above the 32-bit word offset
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready
                  && (paddr[APB_ADDR_W-1:2] == REG_INITIAL_COUNT);
  assign prdata = APB_DATA_W'(cfg_value);

  // sequencer: one state per heap access step
  pcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // counters, heap RAM and the output register
  pcs_datapath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (pwdata[CNT_W-1:0]),
    .cfg_value   (cfg_value),
    .in_kind     (req.kind),
    .in_task     (req.task_id),
    .in_prio     (req.priority_req),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .out_status  (rsp.status),
    .out_task    (rsp.woken_task),
    .out_prio    (rsp.woken_priority),
    .out_waiters (rsp.waiters[WAIT_W-1:0])
  );

endmodule
